// File: hw/rtl/bsfe_pkg.sv
// Shared types, constants and the bit stuffing function of the frame encoder.
package bsfe_pkg;

	// Framing constants.
	localparam logic [7:0] FLAG_BYTE       = 8'h7E;
	localparam logic [7:0] FIRST_ADDR_RST  = 8'd2;
	localparam logic [7:0] SECOND_ADDR_RST = 8'd1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ADDR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ADDR = 1'b1;

	// Queue geometry: four entries, pointers carry one wrap bit.
	localparam int QUEUE_AW = 2;

	// A stuffed byte holds at most ten bits; the bit accumulator holds up to seventeen.
	localparam int STUFF_W = 10;
	localparam int ACC_W   = 17;
	localparam int FILL_W  = 5;

	typedef enum logic {
		OP_FLAG = 1'b0,
		OP_DATA = 1'b1
	} cmd_op_t;

	typedef enum logic [1:0] {
		KIND_FLAG   = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_PARITY = 2'd2
	} kind_t;

	// Work request from the front end to the back end.
	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
		logic       last;
	} cmd_t;

	// One result byte of the framed stream.
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} res_t;

	// Stuffed bits right aligned, their count and the ones run left behind.
	typedef struct packed {
		logic [STUFF_W-1:0] bits;
		logic [3:0]         count;
		logic [2:0]         run;
	} stuff_t;

	// Sends one byte MSB first through the stuffer, inserting a zero after five ones.
	function automatic stuff_t stuff_byte(input logic [7:0] value, input logic [2:0] run_in);
		stuff_t r;
		logic [STUFF_W-1:0] bits;
		logic [3:0] n;
		logic [2:0] rn;
		bits = '0;
		n    = '0;
		rn   = run_in;
		for (int i = 7; i >= 0; i--) begin
			bits = {bits[STUFF_W-2:0], value[i]};
			n    = n + 4'd1;
			if (value[i]) begin
				rn = rn + 3'd1;
				if (rn == 3'd5) begin
					bits = {bits[STUFF_W-2:0], 1'b0};
					n    = n + 4'd1;
					rn   = 3'd0;
				end
			end else begin
				rn = 3'd0;
			end
		end
		r.bits  = bits;
		r.count = n;
		r.run   = rn;
		return r;
	endfunction

endpackage

// File: hw/rtl/bsfe_front.sv
// Front end: takes input requests, holds the address registers and issues work requests.
module bsfe_front
	import bsfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           payload_byte,
	input  logic                 frame_end,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 cmd_push,
	output cmd_t                 cmd,
	input  logic                 cmd_full
);

	logic       hold_q;
	logic       hold_first_q;
	logic [7:0] hold_byte_q;
	logic       hold_last_q;
	logic [1:0] step_q;
	logic       in_frame_q;
	logic [7:0] first_addr_q;
	logic [7:0] second_addr_q;
	logic       final_step;
	logic       accept;

	assign cfg_ready = 1'b1;

	// A frame's first byte expands to flag, two addresses and payload; others to payload only.
	assign final_step = !hold_first_q || (step_q == 2'd3);
	assign cmd_push   = hold_q && !cmd_full;
	assign full       = hold_q && !(cmd_push && final_step);
	assign accept     = push && !full;

	// Pick the work request for the current expansion step.
	always_comb begin
		cmd.op   = OP_DATA;
		cmd.data = hold_byte_q;
		cmd.last = hold_last_q;
		if (hold_first_q) begin
			case (step_q)
				2'd0: begin
					cmd.op   = OP_FLAG;
					cmd.data = FLAG_BYTE;
					cmd.last = 1'b0;
				end
				2'd1: begin
					cmd.data = first_addr_q;
					cmd.last = 1'b0;
				end
				2'd2: begin
					cmd.data = second_addr_q;
					cmd.last = 1'b0;
				end
				default: begin
					cmd.data = hold_byte_q;
					cmd.last = hold_last_q;
				end
			endcase
		end
	end

	// Holding register and expansion step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q     <= 1'b0;
			step_q     <= 2'd0;
			in_frame_q <= 1'b0;
		end else if (accept) begin
			hold_q     <= 1'b1;
			step_q     <= 2'd0;
			in_frame_q <= !frame_end;
		end else if (cmd_push && final_step) begin
			hold_q <= 1'b0;
		end else if (cmd_push) begin
			step_q <= step_q + 2'd1;
		end
	end

	// Captured input request.
	always_ff @(posedge clk) begin
		if (accept) begin
			hold_first_q <= !in_frame_q;
			hold_byte_q  <= payload_byte;
			hold_last_q  <= frame_end;
		end
	end

	// Address registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_addr_q  <= FIRST_ADDR_RST;
			second_addr_q <= SECOND_ADDR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FIRST_ADDR:  first_addr_q  <= cfg_data;
				CFG_SECOND_ADDR: second_addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/bsfe_cmd_queue.sv
// Four-entry queue of work requests between the front end and the back end.
module bsfe_cmd_queue
	import bsfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t              mem_q [2**QUEUE_AW];
	logic [QUEUE_AW:0] wr_ptr_q;
	logic [QUEUE_AW:0] rd_ptr_q;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[QUEUE_AW] != rd_ptr_q[QUEUE_AW]) &&
	                 (wr_ptr_q[QUEUE_AW-1:0] == rd_ptr_q[QUEUE_AW-1:0]);
	assign rd_data = mem_q[rd_ptr_q[QUEUE_AW-1:0]];

	// Pointer update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= wr_ptr_q + (QUEUE_AW+1)'(1);
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= rd_ptr_q + (QUEUE_AW+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q[QUEUE_AW-1:0]] <= wr_data;
		end
	end

endmodule

// File: hw/rtl/bsfe_back.sv
// Back end: stuffs data bytes, packs the bit stream and emits flag, body and parity bytes.
module bsfe_back
	import bsfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_push,
	output res_t res,
	input  logic res_full
);

	logic [ACC_W-1:0]  acc_q;
	logic [FILL_W-1:0] fill_q;
	logic [2:0]        run_q;
	logic              parity_q;
	logic              end_q;

	stuff_t            st;
	logic              emit_full;
	logic [FILL_W-1:0] rem;
	logic              take_flag;
	logic              take_data;
	logic              do_pad;
	logic              do_parity;
	logic [ACC_W-1:0]  body_shift;
	logic [ACC_W-1:0]  pad_shift;
	logic [FILL_W-1:0] pad_amt;

	assign st         = stuff_byte(cmd.data, run_q);
	assign emit_full  = (fill_q >= FILL_W'(8));
	assign rem        = (emit_full && !res_full) ? (fill_q - FILL_W'(8)) : fill_q;
	assign body_shift = acc_q >> (fill_q - FILL_W'(8));
	assign pad_amt    = FILL_W'(8) - fill_q;
	assign pad_shift  = acc_q << pad_amt;

	// Choose the result byte of this cycle: full body byte, tail, parity or flag.
	always_comb begin
		res_push  = 1'b0;
		res.data  = body_shift[7:0];
		res.kind  = KIND_BODY;
		res.last  = 1'b0;
		take_flag = 1'b0;
		do_pad    = 1'b0;
		do_parity = 1'b0;
		if (!res_full) begin
			if (emit_full) begin
				res_push = 1'b1;
			end else if (end_q) begin
				res_push = 1'b1;
				if (fill_q != '0) begin
					do_pad   = 1'b1;
					res.data = pad_shift[7:0];
				end else begin
					do_parity = 1'b1;
					res.data  = {7'd0, parity_q};
					res.kind  = KIND_PARITY;
					res.last  = 1'b1;
				end
			end else if (!cmd_empty && (cmd.op == OP_FLAG)) begin
				res_push  = 1'b1;
				take_flag = 1'b1;
				res.data  = FLAG_BYTE;
				res.kind  = KIND_FLAG;
			end
		end
	end

	// A data byte is taken once the bits left after this cycle's output fit below a byte.
	assign take_data = !cmd_empty && (cmd.op == OP_DATA) && !end_q && (rem < FILL_W'(8));
	assign cmd_pop   = take_flag || take_data;

	// Frame control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			run_q    <= '0;
			parity_q <= 1'b0;
			end_q    <= 1'b0;
		end else if (take_data) begin
			fill_q   <= rem + FILL_W'(st.count);
			run_q    <= st.run;
			parity_q <= parity_q ^ (^cmd.data);
			end_q    <= cmd.last;
		end else if (do_pad) begin
			fill_q <= '0;
		end else if (do_parity) begin
			run_q    <= '0;
			parity_q <= 1'b0;
			end_q    <= 1'b0;
		end else if (emit_full && !res_full) begin
			fill_q <= rem;
		end
	end

	// Bit accumulator, newest bits at the low end.
	always_ff @(posedge clk) begin
		if (take_data) begin
			acc_q <= (acc_q << st.count) | ACC_W'(st.bits);
		end
	end

endmodule

// File: hw/rtl/bsfe_res_queue.sv
// Four-entry queue of result bytes that drives the output side.
module bsfe_res_queue
	import bsfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  res_t wr_data,
	output logic full,
	input  logic rd_en,
	output res_t rd_data,
	output logic empty
);

	res_t              mem_q [2**QUEUE_AW];
	logic [QUEUE_AW:0] wr_ptr_q;
	logic [QUEUE_AW:0] rd_ptr_q;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[QUEUE_AW] != rd_ptr_q[QUEUE_AW]) &&
	                 (wr_ptr_q[QUEUE_AW-1:0] == rd_ptr_q[QUEUE_AW-1:0]);
	assign rd_data = mem_q[rd_ptr_q[QUEUE_AW-1:0]];

	// Pointer update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= wr_ptr_q + (QUEUE_AW+1)'(1);
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= rd_ptr_q + (QUEUE_AW+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q[QUEUE_AW-1:0]] <= wr_data;
		end
	end

endmodule

// File: hw/rtl/bit_stuff_frame_encoder.sv
// Top level of the bit stuffing frame encoder.
//
// Input side is a queue: present payload_byte and frame_end with push; the request
// is taken on a clock edge where push is high and full is low. Output side is a
// queue too: while empty is low, out_byte, out_kind and out_last show the oldest
// result, and pop takes it. Address registers are written on the cfg channel,
// index 0 first address, index 1 second address; cfg_ready is always high.
// A frame's first byte becomes four work requests (flag, both addresses, payload),
// issued in order, with full high until the last one goes; other bytes give one each.
// The back end takes a data byte only while fewer than eight stuffed bits remain
// after its output and writes at most one result byte per cycle, none while the
// result queue is full. A frame's flag passes the holding register, the work queue
// and the result queue; a body byte passes the bit accumulator and the result queue.
// A stalled receiver fills the four-entry result queue, then the four-entry work
// queue, and then full rises; nothing is lost. Reset clears both queues and the
// frame state and loads the addresses with 2 and 1.
module bit_stuff_frame_encoder
	import bsfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           payload_byte,
	input  logic                 frame_end,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           out_byte,
	output logic [1:0]           out_kind,
	output logic                 out_last
);

	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;
	res_t res_in;
	res_t res_head;
	logic res_push;
	logic res_full;

	// Request intake and expansion.
	bsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.payload_byte (payload_byte),
		.frame_end    (frame_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in),
		.cmd_full     (cmd_full)
	);

	// Work queue between the two halves.
	bsfe_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	// Stuffing and byte packing.
	bsfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	// Result queue on the output side.
	bsfe_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty)
	);

	assign out_byte = res_head.data;
	assign out_kind = res_head.kind;
	assign out_last = res_head.last;

endmodule
